/* src/estm_pkg.sv */
// Package: shared constants, item types and fixed-point helpers.
package estm_pkg;

   localparam int TRIG_FRAC_BITS  = 30;
   localparam int VALUE_FRAC_BITS = 16;
   localparam int STEPS           = 32;
   localparam int XY_FRAC         = 40;
   localparam int XY_W            = 43;
   localparam int Z_W             = 42;
   localparam int TRIG_W          = 33;
   localparam int ACC_W           = 68;
   localparam int RND_W           = ACC_W - TRIG_FRAC_BITS;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   // angle reduction: hi = angle >>> 16, kept non-negative by a multiple of 360
   localparam int HI_BIAS     = 360 * 92;
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP_360   = 186414;

   localparam logic signed [XY_W-1:0] GAIN_Q40 = 43'sd667681663043;
   localparam logic signed [Z_W-1:0]  DEG_PER_RAD_Q32 = 42'sd246083499214;

   localparam logic signed [26:0] FULL_DEG    = 27'sd360 <<< VALUE_FRAC_BITS;
   localparam logic signed [26:0] HALF_DEG    = 27'sd180 <<< VALUE_FRAC_BITS;
   localparam logic signed [26:0] QUARTER_DEG = 27'sd90 <<< VALUE_FRAC_BITS;

   // atan(2^-i) in units of 2^-32 degree
   function automatic logic signed [Z_W-1:0] atan_step(input int i);
      logic signed [Z_W-1:0] r;
      unique case (i)
         0:  r = 42'sd193273528320;
         1:  r = 42'sd114096026022;
         2:  r = 42'sd60285206653;
         3:  r = 42'sd30601712202;
         4:  r = 42'sd15360239180;
         5:  r = 42'sd7687607525;
         6:  r = 42'sd3844741810;
         7:  r = 42'sd1922488225;
         8:  r = 42'sd961258780;
         9:  r = 42'sd480631223;
         10: r = 42'sd240315841;
         11: r = 42'sd120157949;
         12: r = 42'sd60078978;
         13: r = 42'sd30039490;
         14: r = 42'sd15019745;
         15: r = 42'sd7509873;
         default: r = DEG_PER_RAD_Q32 >>> i;
      endcase
      return r;
   endfunction

   // round half up by TRIG_FRAC_BITS
   function automatic logic signed [RND_W-1:0] round_t(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] s;
      s = v + (ACC_W'(1) <<< (TRIG_FRAC_BITS - 1));
      return RND_W'(s >>> TRIG_FRAC_BITS);
   endfunction

   typedef struct packed {
      logic signed [Z_W-1:0] z_x;
      logic signed [Z_W-1:0] z_y;
      logic signed [Z_W-1:0] z_z;
      logic [2:0]            flip;
      logic signed [31:0]    scale_x;
      logic signed [31:0]    scale_y;
      logic signed [31:0]    scale_z;
      logic [31:0]           shift_x;
      logic [31:0]           shift_y;
      logic [31:0]           shift_z;
   } work_type;

   typedef struct packed {
      logic [2:0]         flip;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
      logic [95:0]        shift;
   } meta_type;

   typedef struct packed {
      logic push;
      logic pop;
   } qctl_type;

endpackage

/* src/euler_scale_translate_matrix_top.sv */
// Top level: Euler angle rotation with axis scale and translation.
// Takes one item per cycle unless a full queue holds the front end, and gives one result
// item per item, in order. Each angle is reduced modulo 360 degrees and folded in a
// two-stage front end, waits in a four-entry queue, then passes a 32-stage pipelined
// CORDIC per axis (one stage per rotation step) and seven product, rounding, saturation
// and output stages. A stall on the result side freezes the back end; the front end keeps
// taking items until the queue fills.
module euler_scale_translate_matrix_top import estm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // angle_x, angle_y, angle_z, scale_x, scale_y, scale_z, shift_x, shift_y, shift_z
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // xaxis_x, xaxis_y, xaxis_z, yaxis_x, yaxis_y, yaxis_z,
   // zaxis_x, zaxis_y, zaxis_z, pos_x, pos_y, pos_z
   output logic [383:0] rsp_tdata
);

   work_type front_item, q_item;
   logic     front_valid, q_full, q_empty, q_pop;
   qctl_type qctl;

   // reduce and fold angles
   estm_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data(req_tdata),
      .out_valid(front_valid), .out_ready(!q_full), .out_item(front_item)
   );

   assign qctl.push = front_valid && !q_full;
   assign qctl.pop  = q_pop;

   // decouple front and back
   estm_queue u_queue (
      .clock(clock), .reset(reset), .ctl(qctl),
      .wr_item(front_item), .rd_item(q_item), .full(q_full), .empty(q_empty)
   );

   // trig, matrix and scaling
   estm_back u_back (
      .clock(clock), .reset(reset),
      .q_empty(q_empty), .q_item(q_item), .q_pop(q_pop),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp_tdata)
   );

endmodule

/* src/estm_front.sv */
// Front end: accepts items, reduces and folds the three angles.
module estm_front import estm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [287:0]   in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output work_type       out_item
);

   logic        a_valid_ff, a_valid_in, b_valid_ff, b_valid_in;
   logic        en;
   logic [16:0] u_ff [3];
   logic [8:0]  q_ff [3];
   logic [15:0] lo_ff [3];
   logic [287:0] data_a_ff;
   work_type    item_ff, item_in;
   logic [16:0] u_in [3];
   logic [8:0]  q_in [3];

   assign en        = !b_valid_ff || out_ready;
   assign in_ready  = en;
   assign a_valid_in = in_valid;
   assign b_valid_in = a_valid_ff;

   // estimate quotient of the integer degrees by 360
   always_comb begin
      logic signed [17:0] hi;
      logic [34:0]        prod;
      for (int k = 0; k < 3; k++) begin
         hi = 18'(signed'(in_data[32*k+16 +: 16])) + 18'(HI_BIAS);
         u_in[k] = hi[16:0];
         prod = 35'(u_in[k]) * 35'(RECIP_360);
         q_in[k] = prod[RECIP_SHIFT +: 9];
      end
   end

   // remainder, then fold into [-90, 90] degrees
   always_comb begin
      logic [16:0]        rem;
      logic signed [26:0] r;
      logic [2:0]         fl;
      logic signed [Z_W-1:0] z [3];
      for (int k = 0; k < 3; k++) begin
         rem = u_ff[k] - 17'(q_ff[k]) * 17'd360;
         r = signed'({2'b00, rem[8:0], lo_ff[k]});
         fl[k] = 1'b0;
         if (r > HALF_DEG) r = r - FULL_DEG;
         if (r > QUARTER_DEG) begin
            r = r - HALF_DEG;
            fl[k] = 1'b1;
         end else if (r < -QUARTER_DEG) begin
            r = r + HALF_DEG;
            fl[k] = 1'b1;
         end
         z[k] = Z_W'(r) <<< (32 - VALUE_FRAC_BITS);
      end
      item_in.z_x     = z[0];
      item_in.z_y     = z[1];
      item_in.z_z     = z[2];
      item_in.flip    = fl;
      item_in.scale_x = data_a_ff[96 +: 32];
      item_in.scale_y = data_a_ff[128 +: 32];
      item_in.scale_z = data_a_ff[160 +: 32];
      item_in.shift_x = data_a_ff[192 +: 32];
      item_in.shift_y = data_a_ff[224 +: 32];
      item_in.shift_z = data_a_ff[256 +: 32];
   end

   // advance both stages unless the queue holds back
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_a_ff <= in_data;
         item_ff   <= item_in;
         for (int k = 0; k < 3; k++) begin
            u_ff[k]  <= u_in[k];
            q_ff[k]  <= q_in[k];
            lo_ff[k] <= in_data[32*k +: 16];
         end
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = item_ff;

endmodule

/* src/estm_queue.sv */
// Short queue between front end and back end.
module estm_queue import estm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  qctl_type ctl,
   input  work_type wr_item,
   output work_type rd_item,
   output logic     full,
   output logic     empty
);

   work_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full    = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign rd_item = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (ctl.push && !ctl.pop) count_in = count_ff + 1'b1;
      if (!ctl.push && ctl.pop) count_in = count_ff - 1'b1;
   end

   // move pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (ctl.push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (ctl.pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) mem_ff[wr_ptr_ff] <= wr_item;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count overrun");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> !empty) else $error("pop from empty queue");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> (!full || ctl.pop)) else $error("push into full queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (ctl.push && !ctl.pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

endmodule

/* src/estm_cordic.sv */
// Pipelined CORDIC lane: one rotation step per stage.
module estm_cordic import estm_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [Z_W-1:0] z_start,
   output logic signed [XY_W-1:0] cos_raw,
   output logic signed [XY_W-1:0] sin_raw
);

   logic signed [XY_W-1:0] x_ff [STEPS+1];
   logic signed [XY_W-1:0] y_ff [STEPS+1];
   logic signed [Z_W-1:0]  z_ff [STEPS+1];

   // load the start vector
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= GAIN_Q40;
         y_ff[0] <= '0;
         z_ff[0] <= z_start;
      end
   end

   // rotate toward zero residual angle
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [XY_W-1:0] x_in, y_in;
      logic signed [Z_W-1:0]  z_in;
      always_comb begin
         if (z_ff[i] >= 0) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - atan_step(i);
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + atan_step(i);
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
         end
      end
   end

   assign cos_raw = x_ff[STEPS];
   assign sin_raw = y_ff[STEPS];

endmodule

/* src/estm_back.sv */
// Back end: sine/cosine lanes, matrix products, scaling and output register.
module estm_back import estm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_empty,
   input  work_type       q_item,
   output logic           q_pop,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [383:0]   out_data
);

   localparam int LAT = STEPS + 1 + 7;
   localparam logic signed [TRIG_W-1:0] ONE = TRIG_W'(1) <<< TRIG_FRAC_BITS;

   logic en;
   logic [LAT-1:0] v_ff, v_in;
   meta_type meta_ff [STEPS+1];
   logic signed [XY_W-1:0] c_raw [3], s_raw [3];

   // rounded sine/cosine
   logic signed [TRIG_W-1:0] s_ff [3], c_ff [3], s_in [3], c_in [3];
   meta_type m_r_ff;
   // stage P1
   logic signed [65:0] p1_ff [6];
   logic signed [TRIG_W-1:0] sx1_ff, cx1_ff, sz1_ff, cz1_ff, sy1_ff;
   meta_type m1_ff;
   // stage P2
   logic signed [TRIG_W-1:0] czsy_ff, szsy_ff, sx2_ff, cx2_ff, sz2_ff, cz2_ff;
   logic signed [TRIG_W-1:0] e_ff [9];
   meta_type m2_ff;
   // stage P3
   logic signed [65:0] p3_ff [8];
   meta_type m3_ff;
   logic signed [TRIG_W-1:0] e3_ff [9];
   // stage P4
   logic signed [TRIG_W-1:0] e4_ff [9];
   meta_type m4_ff;
   // stage P5
   logic signed [65:0] p5_ff [9];
   logic [95:0] sh5_ff;
   // output
   logic [383:0] out_ff, out_in;

   assign en    = !v_ff[LAT-1] || out_ready;
   assign q_pop = en && !q_empty;

   assign v_in = {v_ff[LAT-2:0], !q_empty};

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (en) v_ff <= v_in;
   end

   // three sine/cosine lanes
   estm_cordic u_cx (.clock(clock), .en(en), .z_start(q_item.z_x),
      .cos_raw(c_raw[0]), .sin_raw(s_raw[0]));
   estm_cordic u_cy (.clock(clock), .en(en), .z_start(q_item.z_y),
      .cos_raw(c_raw[1]), .sin_raw(s_raw[1]));
   estm_cordic u_cz (.clock(clock), .en(en), .z_start(q_item.z_z),
      .cos_raw(c_raw[2]), .sin_raw(s_raw[2]));

   // carry item side data alongside the lanes
   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0] <= '{flip: q_item.flip, scale_x: q_item.scale_x,
                         scale_y: q_item.scale_y, scale_z: q_item.scale_z,
                         shift: {q_item.shift_z, q_item.shift_y, q_item.shift_x}};
         for (int k = 0; k < STEPS; k++) meta_ff[k+1] <= meta_ff[k];
      end
   end

   // round to T bits, clamp to one, unfold
   always_comb begin
      logic signed [XY_W:0] t;
      logic signed [TRIG_W-1:0] cv, sv;
      for (int k = 0; k < 3; k++) begin
         t = ((XY_W+1)'(c_raw[k]) + ((XY_W+1)'(1) <<< (XY_FRAC - TRIG_FRAC_BITS - 1)))
             >>> (XY_FRAC - TRIG_FRAC_BITS);
         if (t > (XY_W+1)'(ONE)) cv = ONE;
         else if (t < -(XY_W+1)'(ONE)) cv = -ONE;
         else cv = TRIG_W'(t);
         t = ((XY_W+1)'(s_raw[k]) + ((XY_W+1)'(1) <<< (XY_FRAC - TRIG_FRAC_BITS - 1)))
             >>> (XY_FRAC - TRIG_FRAC_BITS);
         if (t > (XY_W+1)'(ONE)) sv = ONE;
         else if (t < -(XY_W+1)'(ONE)) sv = -ONE;
         else sv = TRIG_W'(t);
         c_in[k] = meta_ff[STEPS].flip[k] ? -cv : cv;
         s_in[k] = meta_ff[STEPS].flip[k] ? -sv : sv;
      end
   end

   // matrix and scale pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            s_ff[k] <= s_in[k];
            c_ff[k] <= c_in[k];
         end
         m_r_ff <= meta_ff[STEPS];

         // first products
         p1_ff[0] <= 66'(c_ff[2]) * 66'(s_ff[1]);
         p1_ff[1] <= 66'(s_ff[2]) * 66'(s_ff[1]);
         p1_ff[2] <= 66'(c_ff[2]) * 66'(c_ff[1]);
         p1_ff[3] <= 66'(s_ff[2]) * 66'(c_ff[1]);
         p1_ff[4] <= 66'(c_ff[1]) * 66'(s_ff[0]);
         p1_ff[5] <= 66'(c_ff[1]) * 66'(c_ff[0]);
         sx1_ff <= s_ff[0];
         cx1_ff <= c_ff[0];
         sz1_ff <= s_ff[2];
         cz1_ff <= c_ff[2];
         sy1_ff <= s_ff[1];
         m1_ff  <= m_r_ff;

         // round the two-factor terms
         czsy_ff <= TRIG_W'(round_t(ACC_W'(p1_ff[0])));
         szsy_ff <= TRIG_W'(round_t(ACC_W'(p1_ff[1])));
         e_ff[0] <= TRIG_W'(round_t(ACC_W'(p1_ff[2])));
         e_ff[1] <= TRIG_W'(round_t(ACC_W'(p1_ff[3])));
         e_ff[2] <= -sy1_ff;
         e_ff[5] <= TRIG_W'(round_t(ACC_W'(p1_ff[4])));
         e_ff[8] <= TRIG_W'(round_t(ACC_W'(p1_ff[5])));
         e_ff[3] <= '0;
         e_ff[4] <= '0;
         e_ff[6] <= '0;
         e_ff[7] <= '0;
         sx2_ff <= sx1_ff;
         cx2_ff <= cx1_ff;
         sz2_ff <= sz1_ff;
         cz2_ff <= cz1_ff;
         m2_ff  <= m1_ff;

         // products for the mixed terms
         p3_ff[0] <= 66'(czsy_ff) * 66'(sx2_ff);
         p3_ff[1] <= 66'(sz2_ff) * 66'(cx2_ff);
         p3_ff[2] <= 66'(cz2_ff) * 66'(cx2_ff);
         p3_ff[3] <= 66'(szsy_ff) * 66'(sx2_ff);
         p3_ff[4] <= 66'(sz2_ff) * 66'(sx2_ff);
         p3_ff[5] <= 66'(czsy_ff) * 66'(cx2_ff);
         p3_ff[6] <= 66'(szsy_ff) * 66'(cx2_ff);
         p3_ff[7] <= 66'(cz2_ff) * 66'(sx2_ff);
         e3_ff <= e_ff;
         m3_ff <= m2_ff;

         // sum and round the mixed terms
         e4_ff[0] <= e3_ff[0];
         e4_ff[1] <= e3_ff[1];
         e4_ff[2] <= e3_ff[2];
         e4_ff[5] <= e3_ff[5];
         e4_ff[8] <= e3_ff[8];
         e4_ff[3] <= TRIG_W'(round_t(ACC_W'(p3_ff[0]) - ACC_W'(p3_ff[1])));
         e4_ff[4] <= TRIG_W'(round_t(ACC_W'(p3_ff[2]) + ACC_W'(p3_ff[3])));
         e4_ff[6] <= TRIG_W'(round_t(ACC_W'(p3_ff[4]) + ACC_W'(p3_ff[5])));
         e4_ff[7] <= TRIG_W'(round_t(ACC_W'(p3_ff[6]) - ACC_W'(p3_ff[7])));
         m4_ff <= m3_ff;

         // scale each column
         for (int k = 0; k < 3; k++) begin
            p5_ff[k]   <= 66'(e4_ff[k])   * 66'(m4_ff.scale_x);
            p5_ff[k+3] <= 66'(e4_ff[k+3]) * 66'(m4_ff.scale_y);
            p5_ff[k+6] <= 66'(e4_ff[k+6]) * 66'(m4_ff.scale_z);
         end
         sh5_ff <= m4_ff.shift;

         out_ff <= out_in;
      end
   end

   // round, saturate and pack the result item
   always_comb begin
      logic signed [RND_W-1:0] r;
      out_in[383:288] = sh5_ff;
      for (int k = 0; k < 9; k++) begin
         r = round_t(ACC_W'(p5_ff[k]));
         if (r > RND_W'(32'sh7fffffff)) out_in[32*k +: 32] = 32'h7fffffff;
         else if (r < RND_W'(-33'sh80000000)) out_in[32*k +: 32] = 32'h80000000;
         else out_in[32*k +: 32] = r[31:0];
      end
   end

   assign out_valid = v_ff[LAT-1];
   assign out_data  = out_ff;

endmodule

/* sim/euler_scale_translate_matrix_top_tb.sv */
// Testbench for the Euler angle scale and translate matrix block, with a self-checking scoreboard.
module euler_scale_translate_matrix_top_tb;
   import estm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 100;

   // Predict matrix items and keep them in order until the block returns them
   class matrix_scoreboard;
      logic [383:0] matrix_queue[$];
      int           errors;

      longint atan_tab[16] = '{
         64'sd193273528320, 64'sd114096026022, 64'sd60285206653, 64'sd30601712202,
         64'sd15360239180, 64'sd7687607525, 64'sd3844741810, 64'sd1922488225,
         64'sd961258780, 64'sd480631223, 64'sd240315841, 64'sd120157949,
         64'sd60078978, 64'sd30039490, 64'sd15019745, 64'sd7509873};

      function new();
         errors = 0;
      endfunction

      // round half up, floor division by 2^s
      function longint round_by(longint v, int s);
         return (v + (64'sd1 <<< (s - 1))) >>> s;
      endfunction

      function longint unit_clamp(longint v);
         longint one;
         one = 64'sd1 <<< TRIG_FRAC_BITS;
         if (v > one) return one;
         if (v < -one) return -one;
         return v;
      endfunction

      // reduce, fold into a quarter turn, then rotate with CORDIC
      function void angle_trig(longint a, output longint s, output longint c);
         longint full, half, quarter, r, x, y, z, dx, dy, da;
         bit     flip;
         full    = 64'sd360 <<< VALUE_FRAC_BITS;
         half    = 64'sd180 <<< VALUE_FRAC_BITS;
         quarter = 64'sd90 <<< VALUE_FRAC_BITS;
         flip    = 0;
         r = a % full;
         if (r < 0) r += full;
         if (r > half) r -= full;
         if (r > quarter) begin
            r -= half;
            flip = 1;
         end else if (r < -quarter) begin
            r += half;
            flip = 1;
         end
         z = r * (64'sd1 <<< (32 - VALUE_FRAC_BITS));
         x = 64'sd667681663043;
         y = 0;
         for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            da = (i < 16) ? atan_tab[i] : (64'sd246083499214 >>> i);
            if (z >= 0) begin
               x -= dx; y += dy; z -= da;
            end else begin
               x += dx; y -= dy; z += da;
            end
         end
         x = unit_clamp(round_by(x, XY_FRAC - TRIG_FRAC_BITS));
         y = unit_clamp(round_by(y, XY_FRAC - TRIG_FRAC_BITS));
         if (flip) begin
            x = -x;
            y = -y;
         end
         s = y;
         c = x;
      endfunction

      function logic [31:0] scaled(longint e, longint k);
         longint v;
         v = round_by(e * k, TRIG_FRAC_BITS);
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         return v[31:0];
      endfunction

      // note an accepted input item and queue its matrix
      function void note_input(logic [287:0] d);
         longint sx, cx, sy, cy, sz, cz, kx, ky, kz, czsy, szsy;
         longint e[9];
         logic [383:0] m;
         angle_trig(longint'($signed(d[31:0])), sx, cx);
         angle_trig(longint'($signed(d[63:32])), sy, cy);
         angle_trig(longint'($signed(d[95:64])), sz, cz);
         kx = longint'($signed(d[127:96]));
         ky = longint'($signed(d[159:128]));
         kz = longint'($signed(d[191:160]));
         czsy = round_by(cz * sy, TRIG_FRAC_BITS);
         szsy = round_by(sz * sy, TRIG_FRAC_BITS);
         e[0] = round_by(cz * cy, TRIG_FRAC_BITS);
         e[1] = round_by(sz * cy, TRIG_FRAC_BITS);
         e[2] = -sy;
         e[3] = round_by(czsy * sx - sz * cx, TRIG_FRAC_BITS);
         e[4] = round_by(cz * cx + szsy * sx, TRIG_FRAC_BITS);
         e[5] = round_by(cy * sx, TRIG_FRAC_BITS);
         e[6] = round_by(sz * sx + czsy * cx, TRIG_FRAC_BITS);
         e[7] = round_by(szsy * cx - cz * sx, TRIG_FRAC_BITS);
         e[8] = round_by(cy * cx, TRIG_FRAC_BITS);
         for (int j = 0; j < 9; j++)
            m[32*j +: 32] = scaled(e[j], (j < 3) ? kx : (j < 6) ? ky : kz);
         m[383:288] = d[287:192];
         matrix_queue.push_back(m);
      endfunction

      // compare a result item against the oldest prediction, field by field
      function void check_result(logic [383:0] act);
         logic [383:0] exp_m;
         if (matrix_queue.size() == 0) begin
            $display("%0t: unexpected result item %h", $time, act);
            errors++;
            return;
         end
         exp_m = matrix_queue.pop_front();
         for (int j = 0; j < 12; j++)
            if (act[32*j +: 32] !== exp_m[32*j +: 32]) begin
               $display("%0t: field %0d mismatch, expected %h actual %h",
                        $time, j, exp_m[32*j +: 32], act[32*j +: 32]);
               errors++;
            end
      endfunction

      function int pending();
         return matrix_queue.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [287:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [383:0] rsp_tdata;

   matrix_scoreboard sb = new();
   int  tx_idle_pct;
   int  rx_idle_pct;
   bit  hold_request;
   int  hold_count;
   int  quiet_cycles;

   euler_scale_translate_matrix_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 0;
   always #10 clock = ~clock;

   // watch both channels and check results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_input(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   // drive the receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         hold_count <= 0;
      end else if (hold_request) begin
         hold_request = 0;
         hold_count <= HOLD_CYCLES;
         rsp_tready <= 0;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // offer one item, with an optional idle gap first, and hold until accepted
   task automatic send_item(logic [287:0] d);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop offering and wait until every predicted matrix has come back
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   function automatic logic [287:0] pack_item(logic [31:0] ax, ay, az, kx, ky, kz,
                                              tx, ty, tz);
      return {tz, ty, tx, kz, ky, kx, az, ay, az == az ? ax : ax};
   endfunction

   // random item: mostly moderate angles and scales, sometimes any bit pattern
   function automatic logic [287:0] random_item();
      logic [287:0] d;
      for (int j = 0; j < 9; j++) d[32*j +: 32] = $urandom;
      if ($urandom_range(3) != 0) begin
         for (int j = 0; j < 3; j++)
            d[32*j +: 32] = $urandom_range(32'd94371840) - 32'd47185920;
         for (int j = 3; j < 6; j++)
            d[32*j +: 32] = $urandom_range(32'd1048576) - 32'd524288;
      end
      return d;
   endfunction

   // run a phase of random items under the given idle rates
   task automatic random_phase(int n, int tx_pct, int rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int i = 0; i < n; i++) send_item(random_item());
      drain();
   endtask

   localparam logic [31:0] DEG90  = 32'd90 << 16;
   localparam logic [31:0] DEG180 = 32'd180 << 16;
   localparam logic [31:0] DEG360 = 32'd360 << 16;
   localparam logic [31:0] ONE    = 32'h0001_0000;
   localparam logic [31:0] MAXV   = 32'h7fff_ffff;
   localparam logic [31:0] MINV   = 32'h8000_0000;

   initial begin
      reset        = 1;
      req_tvalid   = 0;
      req_tdata    = '0;
      rsp_tready   = 0;
      hold_request = 0;
      quiet_cycles = 0;
      tx_idle_pct  = 0;
      rx_idle_pct  = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: folds, wraps, extremes of angles, saturating scales, shifts
      send_item(pack_item(0, 0, 0, ONE, ONE, ONE, 0, 0, 0));
      send_item(pack_item(DEG90, DEG90, DEG90, ONE, ONE, ONE, MAXV, MINV, 1));
      send_item(pack_item(-DEG90, -DEG90, -DEG90, ONE, ONE, ONE, MINV, MAXV, -1));
      send_item(pack_item(DEG180, -DEG180, DEG180, ONE, ONE, ONE, 1, 2, 3));
      send_item(pack_item(DEG360, -DEG360, DEG90 + 1, ONE, ONE, ONE, 0, 0, 0));
      send_item(pack_item(MINV, MINV, MINV, ONE, ONE, ONE, 0, 0, 0));
      send_item(pack_item(MAXV, MAXV, MAXV, ONE, ONE, ONE, 0, 0, 0));
      send_item(pack_item(MINV, MAXV, 0, MAXV, MAXV, MAXV, 0, 0, 0));
      send_item(pack_item(0, 0, 0, MAXV, MINV, MAXV, 0, 0, 0));
      send_item(pack_item(0, DEG180, 0, MINV, MINV, MINV, 0, 0, 0));
      send_item(pack_item(32'd45 << 16, 32'd30 << 16, 32'd60 << 16,
                          MAXV, MINV, MAXV, 5, 6, 7));
      send_item(pack_item(DEG90 - 1, DEG90 + 1, -DEG90 - 1, ONE, ONE, ONE, 0, 0, 0));
      send_item(pack_item(DEG180 + 1, DEG180 - 1, DEG360 - 1, 0, 0, 0, 0, 0, 0));
      send_item(pack_item(32'hffff_ffff, 1, 32'h8000_0001, MAXV, MAXV, MAXV,
                          MAXV, MAXV, MAXV));
      send_item(pack_item(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678,
                          32'hffff_ffff, 1, MINV, MINV, MINV, MINV));
      drain();

      // fill the block while the receiver holds off
      tx_idle_pct  = 0;
      rx_idle_pct  = 0;
      hold_request = 1;
      for (int i = 0; i < 80; i++) send_item(random_item());
      drain();

      random_phase(510, 14, 67);
      random_phase(510, 67, 14);
      random_phase(510, 0, 0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
